>>> design/tdp_pkg.sv
`default_nettype none

package tdp_pkg;

  // Width of one decimal digit on the result word.
  localparam int DIGIT_W = 4;

  // Width of a residue modulo one hundred.
  localparam int CENT_W = 7;

  // Decimal constants used by the digit readout.
  localparam logic [CENT_W-1:0] CENT_BASE = 7'd100;
  localparam logic [CENT_W-1:0] DEC_BASE  = 7'd10;

  // Status that the serial divider reports to its controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Split a residue below one hundred into tens and ones digits.
  // The tens digit comes from nine independent compares against multiples of ten.
  function automatic logic [2*DIGIT_W-1:0] digit_split(input logic [CENT_W-1:0] r);
    logic [DIGIT_W-1:0] tens;
    logic [CENT_W-1:0]  ones;
    tens = '0;
    for (int k = 1; k <= 9; k++) begin
      if (r >= CENT_W'(k * 10)) begin
        tens = DIGIT_W'(k);
      end
    end
    ones = r - CENT_W'(CENT_W'(tens) * DEC_BASE);
    return {tens, ones[DIGIT_W-1:0]};
  endfunction

endpackage

`default_nettype wire

>>> design/tdp_div.sv
`default_nettype none

module tdp_div
  import tdp_pkg::*;
#(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output div_status_t       status,
  output logic      [W-1:0] quotient,
  output logic      [W-1:0] remainder
);

  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;

  logic [W:0]       trial;
  logic             qbit;
  logic [W-1:0]     rem_next;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial    = {rem, quo[W-1]};
  assign qbit     = (trial >= {1'b0, dvs});
  assign rem_next = qbit ? W'(trial - {1'b0, dvs}) : trial[W-1:0];

  // Control: a run steps through every dividend bit, then done pulses once.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: dividend bits shift out of quo while quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[W-2:0], qbit};
    end
  end

  assign status    = '{busy: busy, done: done};
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

>>> design/trial_division_prime_test.sv
`default_nettype none

// Trial-division primality test with a two-digit decimal readout. Each word
// carries one candidate, reduced to its low NUM_WIDTH bits, and yields one result
// word: a prime flag, plus the tens and ones digits of the candidate modulo 100.
// Zero and one are reported as not prime. Divisors are tried upward from two; a
// single bit-serial restoring divider gives both quotient and remainder, so the
// search ends at the first divisor that divides evenly or whose quotient falls
// below it. Each trial divisor takes one full run of that divider. The number of
// divisors tried is the smallest factor minus one for a composite, or floor(sqrt(n))
// for a prime. Candidates below two wait only for the serial modulo-100 reduction.
// One candidate is in work at a time; the next one is taken as soon as the current
// result has moved to the output register, even if that result is still stalled.
module trial_division_prime_test
  import tdp_pkg::*;
#(
  parameter int NUM_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [31:0]        candidate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    prime,
  output logic      [DIGIT_W-1:0] tens_digit,
  output logic      [DIGIT_W-1:0] ones_digit
);

  localparam int CNT_W = $clog2(NUM_WIDTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                 state;
  logic [NUM_WIDTH-1:0]   num;
  logic [NUM_WIDTH-1:0]   dvs;
  logic                   prime_flag;
  logic [NUM_WIDTH-1:0]   mod_sh;
  logic [CNT_W-1:0]       mod_cnt;
  logic [CENT_W-1:0]      mod_rem;

  logic [NUM_WIDTH+31:0]  cand_ext;
  logic [NUM_WIDTH-1:0]   cand_num;
  logic                   accept_in;
  logic                   out_free;
  logic                   fin_fire;
  logic [NUM_WIDTH-1:0]   dvs_next;
  logic                   div_start;
  logic [NUM_WIDTH-1:0]   div_dividend;
  logic [NUM_WIDTH-1:0]   div_divisor;
  div_status_t            div_st;
  logic [NUM_WIDTH-1:0]   div_q;
  logic [NUM_WIDTH-1:0]   div_r;
  logic                   quo_below;
  logic                   rem_zero;
  logic [CENT_W:0]        mod_sum;
  logic [CENT_W-1:0]      mod_rem_next;
  logic [2*DIGIT_W-1:0]   digits;

  // Take the candidate modulo 2^NUM_WIDTH, whichever side of 32 bits that is.
  assign cand_ext = {{NUM_WIDTH{1'b0}}, candidate};
  assign cand_num = cand_ext[NUM_WIDTH-1:0];

  // Handshake on both sides.
  assign in_stall  = (state != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign fin_fire  = (state == S_FIN) && (mod_cnt == '0) && out_free;

  // Outcome of one trial division.
  assign quo_below = (div_q < dvs);
  assign rem_zero  = (div_r == '0);
  assign dvs_next  = dvs + 1'b1;

  // Start the first trial on accept, and the next one when a trial is inconclusive.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = num;
    div_divisor  = dvs_next;
    if (state == S_IDLE) begin
      div_start    = accept_in && (cand_num >= NUM_WIDTH'(2));
      div_dividend = cand_num;
      div_divisor  = NUM_WIDTH'(2);
    end else if (state == S_DIV) begin
      div_start = div_st.done && !quo_below && !rem_zero;
    end
  end

  tdp_div #(
    .W (NUM_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .status    (div_st),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // Serial modulo-100 reduction, one candidate bit per cycle, MSB first.
  assign mod_sum      = {mod_rem, mod_sh[NUM_WIDTH-1]};
  assign mod_rem_next = (mod_sum >= {1'b0, CENT_BASE}) ?
                        CENT_W'(mod_sum - {1'b0, CENT_BASE}) : mod_sum[CENT_W-1:0];
  assign digits       = digit_split(mod_rem);

  // Control: sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      mod_cnt   <= '0;
    end else begin
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept_in) begin
        mod_cnt <= CNT_W'(NUM_WIDTH);
      end else if (mod_cnt != '0) begin
        mod_cnt <= mod_cnt - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept_in) begin
            state <= (cand_num >= NUM_WIDTH'(2)) ? S_DIV : S_FIN;
          end
        end
        S_DIV: begin
          if (div_st.done && (quo_below || rem_zero)) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath: candidate, divisor, verdict, residue and the output word.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      num        <= cand_num;
      dvs        <= NUM_WIDTH'(2);
      prime_flag <= 1'b0;
      mod_sh     <= cand_num;
      mod_rem    <= '0;
    end else begin
      if (mod_cnt != '0) begin
        mod_sh  <= {mod_sh[NUM_WIDTH-2:0], 1'b0};
        mod_rem <= mod_rem_next;
      end
      if ((state == S_DIV) && div_st.done) begin
        if (quo_below) begin
          prime_flag <= 1'b1;
        end else if (!rem_zero) begin
          dvs <= dvs_next;
        end
      end
    end
    if (fin_fire) begin
      prime      <= prime_flag;
      tens_digit <= digits[2*DIGIT_W-1:DIGIT_W];
      ones_digit <= digits[DIGIT_W-1:0];
    end
  end

endmodule

`default_nettype wire
